// ----- design/assert_macros.svh -----
// Assertion macros shared by the binary rank histogram modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BRH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define BRH_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define BRH_ASSERT(lbl, clk, rst, prop)
`define BRH_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- design/brh_pkg.sv -----
// Types and constants shared by the binary rank histogram modules.
package brh_pkg;

  localparam int MAT_ROWS        = 6;
  localparam int MAT_COLS        = 8;
  localparam int ROW_W           = 8;
  localparam int POS_W           = 3;
  localparam int COL_W           = $clog2(MAT_COLS);
  localparam int RANK_W          = 3;
  localparam int BIN_W           = 2;
  localparam int NUM_BINS        = 4;
  localparam int OUT_COUNT_W     = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [BIN_W-1:0] BIN_FULL      = 2'd0;
  localparam logic [BIN_W-1:0] BIN_MINUS_ONE = 2'd1;
  localparam logic [BIN_W-1:0] BIN_MINUS_TWO = 2'd2;
  localparam logic [BIN_W-1:0] BIN_LOW       = 2'd3;

  typedef logic [MAT_ROWS-1:0][ROW_W-1:0] matrix_t;

  typedef struct packed {
    logic    is_final;
    matrix_t rows;
  } cmd_t;

endpackage

// ----- design/brh_queue.sv -----
// Short command queue between the row gatherer and the rank engine.
`include "assert_macros.svh"

module brh_queue
  import brh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `BRH_NEVER(a_no_write_when_full, clk, rst, wr_en && q_full)
  `BRH_NEVER(a_no_read_when_empty, clk, rst, rd_en && !q_valid)

endmodule

// ----- design/brh_front.sv -----
// Row gatherer: accepts items, builds six-row matrices and queues commands.
module brh_front
  import brh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             kind,
  input  logic [ROW_W-1:0] row_bits,
  input  logic             q_full,
  output logic             cmd_wr,
  output cmd_t             cmd
);

  matrix_t          rows;
  logic [POS_W-1:0] row_pos;
  logic             take;
  logic             last_row;

  assign full     = q_full;
  assign take     = push && !q_full;
  assign last_row = (row_pos == POS_W'(MAT_ROWS - 1));

  always_comb begin
    cmd.is_final           = (kind == KIND_END);
    cmd.rows               = rows;
    cmd.rows[MAT_ROWS-1]   = row_bits;
  end

  assign cmd_wr = take && ((kind == KIND_END) || last_row);

  always_ff @(posedge clk) begin
    if (take && (kind == KIND_ROW)) begin
      rows[row_pos] <= row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
    end else if (take) begin
      if ((kind == KIND_END) || last_row) begin
        row_pos <= '0;
      end else begin
        row_pos <= row_pos + 1'b1;
      end
    end
  end

endmodule

// ----- design/brh_back.sv -----
// Rank engine: column-serial GF(2) elimination, bin counters and result register.
`include "assert_macros.svh"

module brh_back
  import brh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_rd,
  output logic                   empty,
  input  logic                   pop,
  output logic                   is_final,
  output logic [RANK_W-1:0]      rank,
  output logic [BIN_W-1:0]       rank_bin,
  output logic [OUT_COUNT_W-1:0] count_full,
  output logic [OUT_COUNT_W-1:0] count_minus_one,
  output logic [OUT_COUNT_W-1:0] count_minus_two,
  output logic [OUT_COUNT_W-1:0] count_low,
  output logic [OUT_COUNT_W-1:0] matrix_count
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ELIM = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  state_t                  state;
  state_t                  state_next;
  logic [ROW_W-1:0]        m [MAT_ROWS];
  logic [ROW_W-1:0]        m_sw [MAT_ROWS];
  logic [ROW_W-1:0]        m_next [MAT_ROWS];
  logic [RANK_W-1:0]       r;
  logic [RANK_W-1:0]       r_next;
  logic [COL_W-1:0]        col;
  logic [COL_W-1:0]        bit_idx;
  logic [RANK_W-1:0]       pidx;
  logic                    found;
  logic [ROW_W-1:0]        piv_row;
  logic [COUNT_WIDTH-1:0]  cnt [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  total;
  logic [COUNT_WIDTH-1:0]  cnt_inc [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  total_inc;
  logic [BIN_W-1:0]        bin;
  logic                    out_valid;
  logic                    out_free;
  logic                    load_final;
  logic                    load_matrix;
  logic                    elim_end;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign bit_idx  = COL_W'(MAT_COLS - 1) - col;

  always_comb begin
    found = 1'b0;
    pidx  = r;
    for (int i = 0; i < MAT_ROWS; i++) begin
      if (!found && (RANK_W'(i) >= r) && m[i][bit_idx]) begin
        found = 1'b1;
        pidx  = RANK_W'(i);
      end
    end
    for (int i = 0; i < MAT_ROWS; i++) begin
      m_sw[i] = m[i];
    end
    if (found) begin
      m_sw[r]    = m[pidx];
      m_sw[pidx] = m[r];
    end
    piv_row = m_sw[r];
    for (int i = 0; i < MAT_ROWS; i++) begin
      if (found && (RANK_W'(i) != r) && m_sw[i][bit_idx]) begin
        m_next[i] = m_sw[i] ^ piv_row;
      end else begin
        m_next[i] = m_sw[i];
      end
    end
    r_next = r + RANK_W'(found);
  end

  assign elim_end = (col == COL_W'(MAT_COLS - 1)) || (r_next == RANK_W'(MAT_ROWS));

  always_comb begin
    if (r == RANK_W'(MAT_ROWS)) begin
      bin = BIN_FULL;
    end else if (r == RANK_W'(MAT_ROWS - 1)) begin
      bin = BIN_MINUS_ONE;
    end else if (r == RANK_W'(MAT_ROWS - 2)) begin
      bin = BIN_MINUS_TWO;
    end else begin
      bin = BIN_LOW;
    end
    for (int b = 0; b < NUM_BINS; b++) begin
      if ((BIN_W'(b) == bin) && (cnt[b] != COUNT_MAX)) begin
        cnt_inc[b] = cnt[b] + 1'b1;
      end else begin
        cnt_inc[b] = cnt[b];
      end
    end
    total_inc = (total != COUNT_MAX) ? total + 1'b1 : total;
  end

  always_comb begin
    state_next  = state;
    q_rd        = 1'b0;
    load_final  = 1'b0;
    load_matrix = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.is_final) begin
            if (out_free) begin
              q_rd       = 1'b1;
              load_final = 1'b1;
            end
          end else begin
            q_rd       = 1'b1;
            state_next = S_ELIM;
          end
        end
      end
      S_ELIM: begin
        if (elim_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_matrix = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      for (int i = 0; i < MAT_ROWS; i++) begin
        m[i] <= q_cmd.rows[i];
      end
      r   <= '0;
      col <= '0;
    end else if (state == S_ELIM) begin
      for (int i = 0; i < MAT_ROWS; i++) begin
        m[i] <= m_next[i];
      end
      r   <= r_next;
      col <= col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        cnt[b] <= '0;
      end
      total <= '0;
    end else if (load_final) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        cnt[b] <= '0;
      end
      total <= '0;
    end else if (load_matrix) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        cnt[b] <= cnt_inc[b];
      end
      total <= total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_final || load_matrix) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_final) begin
      is_final        <= 1'b1;
      rank            <= '0;
      rank_bin        <= BIN_FULL;
      count_full      <= OUT_COUNT_W'(cnt[0]);
      count_minus_one <= OUT_COUNT_W'(cnt[1]);
      count_minus_two <= OUT_COUNT_W'(cnt[2]);
      count_low       <= OUT_COUNT_W'(cnt[3]);
      matrix_count    <= OUT_COUNT_W'(total);
    end else if (load_matrix) begin
      is_final        <= 1'b0;
      rank            <= r;
      rank_bin        <= bin;
      count_full      <= OUT_COUNT_W'(cnt_inc[0]);
      count_minus_one <= OUT_COUNT_W'(cnt_inc[1]);
      count_minus_two <= OUT_COUNT_W'(cnt_inc[2]);
      count_low       <= OUT_COUNT_W'(cnt_inc[3]);
      matrix_count    <= OUT_COUNT_W'(total_inc);
    end
  end

  `BRH_ASSERT(a_rank_within_cols, clk, rst, (state == S_ELIM) |-> (r <= RANK_W'(col)))
  `BRH_ASSERT(a_rank_max, clk, rst, !empty |-> (rank <= RANK_W'(MAT_ROWS)))
  `BRH_ASSERT(a_final_rank_zero, clk, rst, $past(load_final) |-> (is_final && rank == '0))

endmodule

// ----- design/binary_rank_6x8_histogram.sv -----
// Flow: a matrix is queued with its sixth row, read by the idle engine, eliminated column by
// column and loaded into the result register when it is free; an end-of-stream report is
// queued and loaded into the result register when the engine is idle and the register is free.
// Throughput: one item a cycle while the two-entry command queue has room; the rank engine
// eliminates one column a cycle and takes no new command until its matrix result is loaded.
// Reset: synchronous rst clears the row position, queue, engine state, counters and result
// flag; the stored rows are not reset.
module binary_rank_6x8_histogram
  import brh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind,
  input  logic [ROW_W-1:0]       row_bits,
  output logic                   empty,
  input  logic                   pop,
  output logic                   is_final,
  output logic [RANK_W-1:0]      rank,
  output logic [BIN_W-1:0]       rank_bin,
  output logic [OUT_COUNT_W-1:0] count_full,
  output logic [OUT_COUNT_W-1:0] count_minus_one,
  output logic [OUT_COUNT_W-1:0] count_minus_two,
  output logic [OUT_COUNT_W-1:0] count_low,
  output logic [OUT_COUNT_W-1:0] matrix_count
);

  logic q_full;
  logic q_valid;
  logic cmd_wr;
  logic q_rd;
  cmd_t cmd;
  cmd_t q_cmd;

  brh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .row_bits (row_bits),
    .q_full   (q_full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd)
  );

  brh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_cmd  (q_cmd),
    .q_valid (q_valid)
  );

  brh_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .is_final        (is_final),
    .rank            (rank),
    .rank_bin        (rank_bin),
    .count_full      (count_full),
    .count_minus_one (count_minus_one),
    .count_minus_two (count_minus_two),
    .count_low       (count_low),
    .matrix_count    (matrix_count)
  );

endmodule
